// File: rtl/core/lbps_pkg.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer package
// Shared beat types, command and phase codes, register map and the constants
// of the on-time calculation.
// ----------------------------------------------------------------------------
package lbps_pkg;

  // Command codes carried by an input beat.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;
  localparam logic [1:0] REQ_RESET = 2'd3;

  // Pattern phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ON   = 2'd1;
  localparam logic [1:0] PH_OFF  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // Configuration register map.
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_CYCLE_MS     = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_ON_RATIO     = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_COUNTED_MODE = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_BLINK_LIMIT  = 8'd3;

  // Register values after reset.
  localparam logic [15:0] CycleMsRst     = 16'd1000;
  localparam logic [6:0]  OnRatioRst     = 7'd50;
  localparam logic        CountedModeRst = 1'b0;
  localparam logic [15:0] BlinkLimitRst  = 16'd0;

  // On time is floor(cycle_ms * ratio / 100). The product fits in 23 bits;
  // the division uses ceil(2^30 / 100), which is exact over that range.
  localparam logic [6:0]  RatioMax    = 7'd100;
  localparam int unsigned ProdW       = 23;
  localparam int unsigned RecipW      = 24;
  localparam int unsigned RecipShift  = 30;
  localparam logic [RecipW-1:0] RecipM = 24'd10737419;

  // Cycles the derived timing needs to follow a register write.
  localparam logic [1:0] SettleCycles = 2'd3;

  typedef struct packed {
    logic [15:0] cycle_ms;
    logic [6:0]  on_ratio;
    logic        counted_mode;
    logic [15:0] blink_limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic        full_duty;
  } timing_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic        led_on;
    logic        active;
    logic [1:0]  phase_code;
    logic [15:0] cycles_done;
  } out_beat_t;

endpackage

// File: rtl/core/lbps_timing.sv
// ----------------------------------------------------------------------------
// LED blink phase timing
// Derives the on and off durations from the configuration registers in a
// three-stage pipeline: duty product, reciprocal divide, off-time subtract.
// ----------------------------------------------------------------------------
module lbps_timing (
  input  logic            clk_i,
  input  lbps_pkg::cfg_t  cfg_i,
  output lbps_pkg::timing_t timing_o
);

  logic [6:0]                                    ratio;
  logic [lbps_pkg::ProdW-1:0]                    prod_d, prod_q;
  logic [lbps_pkg::ProdW+lbps_pkg::RecipW-1:0]   recip_prod;
  logic [15:0]                                   on_ms_d, on_ms_q;
  logic [15:0]                                   off_ms_d, off_ms_q;
  logic [15:0]                                   on_ms_hold_q;

  // Stage one: clamp the ratio to one hundred percent and form the product.
  assign ratio  = (cfg_i.on_ratio > lbps_pkg::RatioMax) ? lbps_pkg::RatioMax
                                                        : cfg_i.on_ratio;
  assign prod_d = lbps_pkg::ProdW'(cfg_i.cycle_ms) * lbps_pkg::ProdW'(ratio);

  // Stage two: divide by one hundred through the reciprocal.
  assign recip_prod = (lbps_pkg::ProdW + lbps_pkg::RecipW)'(prod_q) *
                      (lbps_pkg::ProdW + lbps_pkg::RecipW)'(lbps_pkg::RecipM);
  assign on_ms_d    = recip_prod[lbps_pkg::RecipShift +: 16];

  // Stage three: the off time is the rest of the period.
  assign off_ms_d = cfg_i.cycle_ms - on_ms_q;

  always_ff @(posedge clk_i) begin
    prod_q       <= prod_d;
    on_ms_q      <= on_ms_d;
    off_ms_q     <= off_ms_d;
    on_ms_hold_q <= on_ms_q;
  end

  // The on time never exceeds the period, so full duty means no off time.
  assign timing_o.on_ms     = on_ms_hold_q;
  assign timing_o.off_ms    = off_ms_q;
  assign timing_o.full_duty = (off_ms_q == 16'd0);

endmodule

// File: rtl/core/lbps_core.sv
// ----------------------------------------------------------------------------
// LED blink sequencer core
// Input register, phase state update and result register. Unless stalled or
// held, one beat is processed per cycle; the phase state is updated with the result.
// ----------------------------------------------------------------------------
module lbps_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 hold_i,
  input  lbps_pkg::cfg_t       cfg_i,
  input  lbps_pkg::timing_t    timing_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lbps_pkg::in_beat_t   in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lbps_pkg::out_beat_t  out_beat_o
);

  logic                 in_valid_q;
  lbps_pkg::in_beat_t   in_beat_q;
  logic                 out_valid_q;
  lbps_pkg::out_beat_t  out_beat_d, out_beat_q;
  logic                 out_free, fire, accept;

  logic [1:0]  phase_d, phase_q;
  logic [31:0] start_ms_d, start_ms_q;
  logic [15:0] count_d, count_q;
  logic [31:0] elapsed;
  logic [15:0] count_inc;
  logic        on_last;

  // Handshake: the result register frees up when empty or being taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = hold_i || (in_valid_q && !out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_beat_q <= in_beat_i;
    end
  end

  // Helpers for the tick checks.
  assign elapsed   = in_beat_q.now_ms - start_ms_q;
  assign count_inc = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;
  assign on_last   = cfg_i.counted_mode && timing_i.full_duty &&
                     (({1'b0, count_q} + 17'd1) >= {1'b0, cfg_i.blink_limit});

  // Phase state update for the beat in the input register.
  always_comb begin
    phase_d    = phase_q;
    start_ms_d = start_ms_q;
    count_d    = count_q;
    unique case (in_beat_q.req_type)
      lbps_pkg::REQ_START: begin
        count_d    = 16'd0;
        start_ms_d = in_beat_q.now_ms;
        if (cfg_i.on_ratio == 7'd0) begin
          phase_d = cfg_i.counted_mode ? lbps_pkg::PH_DONE : lbps_pkg::PH_OFF;
        end else begin
          phase_d = lbps_pkg::PH_ON;
        end
      end
      lbps_pkg::REQ_STOP: begin
        phase_d = lbps_pkg::PH_IDLE;
      end
      lbps_pkg::REQ_RESET: begin
        phase_d    = lbps_pkg::PH_IDLE;
        start_ms_d = 32'd0;
        count_d    = 16'd0;
      end
      lbps_pkg::REQ_TICK: begin
        unique case (phase_q)
          lbps_pkg::PH_ON: begin
            if (elapsed >= {16'd0, timing_i.on_ms}) begin
              start_ms_d = in_beat_q.now_ms;
              phase_d    = on_last ? lbps_pkg::PH_DONE : lbps_pkg::PH_OFF;
            end
          end
          lbps_pkg::PH_OFF: begin
            if (elapsed >= {16'd0, timing_i.off_ms}) begin
              start_ms_d = in_beat_q.now_ms;
              count_d    = count_inc;
              if (cfg_i.counted_mode && (count_inc >= cfg_i.blink_limit)) begin
                phase_d = lbps_pkg::PH_DONE;
              end else begin
                phase_d = lbps_pkg::PH_ON;
              end
            end
          end
          lbps_pkg::PH_IDLE, lbps_pkg::PH_DONE: begin
            // Not running: a tick changes nothing.
          end
        endcase
      end
    endcase
  end

  // The led is lit only in the on phase; the pattern runs in on and off.
  always_comb begin
    out_beat_d.led_on      = (phase_d == lbps_pkg::PH_ON);
    out_beat_d.active      = (phase_d == lbps_pkg::PH_ON) ||
                             (phase_d == lbps_pkg::PH_OFF);
    out_beat_d.phase_code  = phase_d;
    out_beat_d.cycles_done = count_d;
  end

  // Phase state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lbps_pkg::PH_IDLE;
      start_ms_q  <= 32'd0;
      count_q     <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q    <= phase_d;
        start_ms_q <= start_ms_d;
        count_q    <= count_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

// File: rtl/core/led_blink_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer
// Duty-cycle LED blinker driven by timestamped tick and command beats, with
// continuous and counted modes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_beat_i): each beat is a tick,
//   start, stop or reset command with the current millisecond timestamp.
//   Output channel (out_valid_o / out_stall_i / out_beat_o): exactly one
//   result beat per input beat, in order: led level, running flag, phase and
//   completed cycle count after the update.
//   Configuration channel (cfg_valid_i / cfg_ready_o): register index and
//   data; always ready. Write only while no beat is in flight.
//   A beat accepted into the input register passes through the combinational
//   phase update into the result register. Throughput: one beat per cycle,
//   unless the receiver stalls or the input is held while the timing settles.
//   After reset and after each register write, the input channel stalls
//   while the on/off durations are rederived (multiply, divide by one
//   hundred, subtract).
//   When the receiver stalls, the result holds and the input register takes
//   one more beat only if it was empty; then the input channel stalls as well.
//   Reset clears the phase to idle, the count and phase timestamp to zero and
//   loads the register defaults.
// ----------------------------------------------------------------------------
module led_blink_pattern_sequencer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  lbps_pkg::in_beat_t                 in_beat_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output lbps_pkg::out_beat_t                out_beat_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lbps_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [lbps_pkg::CfgDataW-1:0]      cfg_data_i
);

  lbps_pkg::cfg_t    cfg_q;
  lbps_pkg::timing_t timing;
  logic [1:0]        settle_q;
  logic              cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cycle_ms     <= lbps_pkg::CycleMsRst;
      cfg_q.on_ratio     <= lbps_pkg::OnRatioRst;
      cfg_q.counted_mode <= lbps_pkg::CountedModeRst;
      cfg_q.blink_limit  <= lbps_pkg::BlinkLimitRst;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        lbps_pkg::REG_CYCLE_MS:     cfg_q.cycle_ms     <= cfg_data_i[15:0];
        lbps_pkg::REG_ON_RATIO:     cfg_q.on_ratio     <= cfg_data_i[6:0];
        lbps_pkg::REG_COUNTED_MODE: cfg_q.counted_mode <= cfg_data_i[0];
        lbps_pkg::REG_BLINK_LIMIT:  cfg_q.blink_limit  <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Hold off input beats until the derived timing has caught up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= lbps_pkg::SettleCycles;
    end else if (cfg_write) begin
      settle_q <= lbps_pkg::SettleCycles;
    end else if (settle_q != 2'd0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  lbps_timing u_timing (
    .clk_i    (clk_i),
    .cfg_i    (cfg_q),
    .timing_o (timing)
  );

  lbps_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hold_i      (settle_q != 2'd0),
    .cfg_i       (cfg_q),
    .timing_i    (timing),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
